// ===== sv/mrp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the MAXRECTS best-short-side-fit packer.
// No dependencies; imported by mrp_ctrl, mrp_datapath and the top level.
package mrp_pkg;

  // Fixed field widths of the request and result transactions
  localparam int IMG_BITS       = 13;
  localparam int POS_BITS       = 12;
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_BIN_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BIN_HEIGHT = 2'd1;

  typedef struct packed {
    logic [IMG_BITS-1:0] image_width;
    logic [IMG_BITS-1:0] image_height;
  } request_t;

  typedef struct packed {
    logic                placed_ok;
    logic [POS_BITS-1:0] place_x;
    logic [POS_BITS-1:0] place_y;
    logic                list_overflow;
  } result_t;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_INIT,
    OP_SCAN,
    OP_SPLIT,
    OP_PRUNE,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic first;   // first cycle of a phase: datapath clears its counters
    logic accept;  // request transaction taken this cycle
  } cmd_t;

  typedef struct packed {
    logic reinit;
    logic scan_done;
    logic found;
    logic split_done;
    logic prune_done;
  } status_t;

endpackage

// ===== sv/mrp_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mrp_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 256,
  localparam int ABITS = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/mrp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the packer: sequences init, scan, split, prune and finish.
// Depends on mrp_pkg.
module mrp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  mrp_pkg::status_t status,
  output mrp_pkg::cmd_t    cmd
);
  import mrp_pkg::*;

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_SPLIT  = 6'b001000,
    S_PRUNE  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   first;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        // a register write during init rebuilds the whole-bin entry again
        state_next = status.reinit ? S_INIT : S_IDLE;
      end
      S_IDLE: begin
        if (status.reinit) begin
          state_next = S_INIT;
        end else if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_next = status.found ? S_SPLIT : S_FINISH;
        end
      end
      S_SPLIT: begin
        if (status.split_done) begin
          state_next = S_PRUNE;
        end
      end
      S_PRUNE: begin
        if (status.prune_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      first <= 1'b1;
    end else begin
      state <= state_next;
      first <= (state_next != state);
    end
  end

  // Command decode
  always_comb begin
    cmd.first  = first;
    cmd.accept = (state == S_IDLE) && start && !status.reinit;
    case (state)
      S_INIT:   cmd.op = OP_INIT;
      S_SCAN:   cmd.op = OP_SCAN;
      S_SPLIT:  cmd.op = OP_SPLIT;
      S_PRUNE:  cmd.op = OP_PRUNE;
      S_FINISH: cmd.op = OP_FINISH;
      default:  cmd.op = OP_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== sv/mrp_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the packer: bin registers, free list and scratch memories,
// fit scan, split, prune and commit. Depends on mrp_pkg and mrp_ram.
module mrp_datapath #(
  parameter int MAX_FREE_RECTS = 256,
  parameter int COORD_BITS     = 13
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mrp_pkg::cmd_t                        cmd,
  output mrp_pkg::status_t                     status,
  input  mrp_pkg::request_t                    request,
  input  logic                                 wr_en,
  input  logic [mrp_pkg::CFG_INDEX_BITS-1:0]   wr_index,
  input  logic [mrp_pkg::IMG_BITS-1:0]         wr_data,
  output logic                                 done,
  output mrp_pkg::result_t                     result
);
  import mrp_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int AW  = ((C > IMG_BITS) ? C : IMG_BITS) + 1;
  localparam int RW  = 4 * C;
  localparam int SA  = $clog2(MAX_FREE_RECTS);
  localparam int SD  = 2 * (1 << SA);
  localparam int XD  = 4 * MAX_FREE_RECTS;
  localparam int XA  = $clog2(XD);
  localparam int NW  = $clog2(XD + 1);
  localparam int CW  = $clog2(MAX_FREE_RECTS + 1);
  localparam logic [AW-1:0] CMAX = AW'((1 << C) - 1);
  localparam logic [NW-1:0] NMAX = NW'(MAX_FREE_RECTS);

  typedef struct packed {
    logic [C-1:0] x;
    logic [C-1:0] y;
    logic [C-1:0] w;
    logic [C-1:0] h;
  } rect_t;

  // a lies inside b
  function automatic logic contains(rect_t a, rect_t b);
    return (AW'(a.x) >= AW'(b.x)) && (AW'(a.y) >= AW'(b.y)) &&
           (AW'(a.x) + AW'(a.w) <= AW'(b.x) + AW'(b.w)) &&
           (AW'(a.y) + AW'(a.h) <= AW'(b.y) + AW'(b.h));
  endfunction

  // Registers
  logic [IMG_BITS-1:0] bin_w, bin_h;
  logic [IMG_BITS-1:0] iw, ih;
  logic                bank;
  logic [CW-1:0]       count;
  logic [NW-1:0]       idx;
  logic                pend;
  logic [AW-1:0]       best_s, best_l;
  logic                found;
  logic [C-1:0]        px, py;
  logic [2:0]          step;
  logic [NW-1:0]       n;
  logic [NW-1:0]       m, mdx;
  logic [1:0]          stage;
  logic                kill;
  rect_t               sk;
  logic [NW-1:0]       surv;

  // Memory ports
  logic                st_we, st_re;
  logic [SA:0]         st_waddr, st_raddr;
  logic [RW-1:0]       st_wdata, st_rdata;
  logic                sc_we, sc_re;
  logic [XA-1:0]       sc_waddr, sc_raddr;
  logic [RW-1:0]       sc_wdata, sc_rdata;

  mrp_ram #(.WIDTH(RW), .DEPTH(SD)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );

  mrp_ram #(.WIDTH(RW), .DEPTH(XD)) u_scratch (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
    .re(sc_re), .raddr(sc_raddr), .rdata(sc_rdata)
  );

  // Free-list entry and placed rectangle geometry
  rect_t         f, e, whole, r0, r1, r2, r3;
  logic [AW-1:0] fx, fy, fw, fh, fr, fb, iwe, ihe, pxe, pye, pre, pbe;
  logic [AW-1:0] lw, lh, ls, ll;
  logic          fits, better, ov, c0, c1, c2, c3;
  logic          scan_rd, in_scan, in_split, in_prune, kill_hit;
  logic [NW-1:0] cnt_n;

  always_comb begin
    f   = rect_t'(st_rdata);
    e   = rect_t'(sc_rdata);
    fx  = AW'(f.x);
    fy  = AW'(f.y);
    fw  = AW'(f.w);
    fh  = AW'(f.h);
    fr  = fx + fw;
    fb  = fy + fh;
    iwe = AW'(iw);
    ihe = AW'(ih);
    pxe = AW'(px);
    pye = AW'(py);
    pre = pxe + iwe;
    pbe = pye + ihe;
    cnt_n = NW'(count);

    // Best short side fit
    fits   = (iwe <= fw) && (ihe <= fh);
    lw     = fw - iwe;
    lh     = fh - ihe;
    ls     = (lw < lh) ? lw : lh;
    ll     = (lw < lh) ? lh : lw;
    better = fits && ((ls < best_s) || ((ls == best_s) && (ll < best_l)));

    // Split remainders: left, right, top, bottom
    ov = (pxe < fr) && (pre > fx) && (pye < fb) && (pbe > fy);
    c0 = (pxe > fx) && (pxe < fr);
    c1 = (pre < fr);
    c2 = (pye > fy) && (pye < fb);
    c3 = (pbe < fb);
    r0 = '{x: f.x, y: f.y, w: C'(pxe - fx), h: f.h};
    r1 = '{x: C'(pre), y: f.y, w: C'(fr - pre), h: f.h};
    r2 = '{x: f.x, y: f.y, w: f.w, h: C'(pye - fy)};
    r3 = '{x: f.x, y: C'(pbe), w: f.w, h: C'(fb - pbe)};

    // Whole-bin entry, dimensions saturated to the coordinate range
    whole.x = '0;
    whole.y = '0;
    whole.w = (AW'(bin_w) > CMAX) ? C'(CMAX) : C'(bin_w);
    whole.h = (AW'(bin_h) > CMAX) ? C'(CMAX) : C'(bin_h);

    kill_hit = (mdx != idx) && contains(sk, e) && (!contains(e, sk) || (mdx > idx));

    in_scan  = (cmd.op == OP_SCAN) && !cmd.first;
    in_split = (cmd.op == OP_SPLIT) && !cmd.first;
    in_prune = (cmd.op == OP_PRUNE) && !cmd.first;
    scan_rd  = in_scan && (idx < cnt_n);
  end

  // Status
  always_comb begin
    status.reinit     = wr_en && ((wr_index == REG_BIN_WIDTH) ||
                                  (wr_index == REG_BIN_HEIGHT));
    status.scan_done  = in_scan && (idx == cnt_n) && !pend;
    status.found      = found;
    status.split_done = in_split && (step == 3'd0) && (idx == cnt_n);
    status.prune_done = in_prune && (stage == 2'd0) && (idx == n);
  end

  // Memory port control
  always_comb begin
    st_we    = 1'b0;
    st_waddr = {bank, SA'(0)};
    st_wdata = RW'(whole);
    st_re    = 1'b0;
    st_raddr = {bank, idx[SA-1:0]};
    sc_we    = 1'b0;
    sc_waddr = n[XA-1:0];
    sc_wdata = RW'(f);
    sc_re    = 1'b0;
    sc_raddr = idx[XA-1:0];
    case (cmd.op)
      OP_INIT: st_we = 1'b1;
      OP_SCAN: st_re = scan_rd;
      OP_SPLIT: begin
        if (in_split) begin
          case (step)
            3'd0: st_re = (idx < cnt_n);
            3'd1: begin
              sc_we    = !ov || c0;
              sc_wdata = ov ? RW'(r0) : RW'(f);
            end
            3'd2: begin
              sc_we    = ov && c1;
              sc_wdata = RW'(r1);
            end
            3'd3: begin
              sc_we    = ov && c2;
              sc_wdata = RW'(r2);
            end
            3'd4: begin
              sc_we    = ov && c3;
              sc_wdata = RW'(r3);
            end
            default: sc_we = 1'b0;
          endcase
        end
      end
      OP_PRUNE: begin
        if (in_prune) begin
          case (stage)
            2'd0: sc_re = (idx < n);
            2'd2: begin
              sc_re    = (m < n);
              sc_raddr = m[XA-1:0];
            end
            2'd3: begin
              st_we    = !kill && (surv < NMAX);
              st_waddr = {~bank, surv[SA-1:0]};
              st_wdata = RW'(sk);
            end
            default: sc_re = 1'b0;
          endcase
        end
      end
      default: st_we = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_w <= IMG_BITS'(1024);
      bin_h <= IMG_BITS'(1024);
      bank  <= 1'b0;
      count <= CW'(1);
      done  <= 1'b0;
    end else begin
      done <= (cmd.op == OP_FINISH);
      if (wr_en && (wr_index == REG_BIN_WIDTH)) begin
        bin_w <= wr_data;
      end
      if (wr_en && (wr_index == REG_BIN_HEIGHT)) begin
        bin_h <= wr_data;
      end
      if (cmd.op == OP_INIT) begin
        count <= CW'(1);
      end
      if ((cmd.op == OP_FINISH) && found && (surv <= NMAX)) begin
        bank  <= ~bank;
        count <= CW'(surv);
      end
    end
  end

  // Phase registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      iw <= request.image_width;
      ih <= request.image_height;
    end
    if (cmd.first) begin
      idx   <= '0;
      pend  <= 1'b0;
      step  <= 3'd0;
      stage <= 2'd0;
      m     <= '0;
      kill  <= 1'b0;
      if (cmd.op == OP_SCAN) begin
        best_s <= '1;
        best_l <= '1;
        found  <= 1'b0;
      end
      if (cmd.op == OP_SPLIT) begin
        n <= '0;
      end
      if (cmd.op == OP_PRUNE) begin
        surv <= '0;
      end
    end else begin
      case (cmd.op)
        // Fit scan: one entry read per cycle, compared once its registered read data returns
        OP_SCAN: begin
          pend <= scan_rd;
          if (scan_rd) begin
            idx <= idx + NW'(1);
          end
          if (pend && better) begin
            best_s <= ls;
            best_l <= ll;
            px     <= f.x;
            py     <= f.y;
            found  <= 1'b1;
          end
        end
        // Split: read an entry, then one remainder slot per cycle
        OP_SPLIT: begin
          if (sc_we) begin
            n <= n + NW'(1);
          end
          case (step)
            3'd0: begin
              if (idx < cnt_n) begin
                step <= 3'd1;
              end
            end
            3'd4: begin
              step <= 3'd0;
              idx  <= idx + NW'(1);
            end
            default: step <= step + 3'd1;
          endcase
        end
        // Prune: hold one candidate, sweep all others past it
        OP_PRUNE: begin
          case (stage)
            2'd0: begin
              if (idx < n) begin
                stage <= 2'd1;
              end
            end
            2'd1: begin
              sk    <= rect_t'(sc_rdata);
              m     <= '0;
              pend  <= 1'b0;
              kill  <= 1'b0;
              stage <= 2'd2;
            end
            2'd2: begin
              pend <= (m < n);
              if (m < n) begin
                mdx <= m;
                m   <= m + NW'(1);
              end
              if (pend && kill_hit) begin
                kill <= 1'b1;
              end
              if ((m == n) && !pend) begin
                stage <= 2'd3;
              end
            end
            default: begin
              if (!kill) begin
                surv <= surv + NW'(1);
              end
              idx   <= idx + NW'(1);
              stage <= 2'd0;
            end
          endcase
        end
        default: pend <= 1'b0;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      result.placed_ok     <= found && (surv <= NMAX);
      result.list_overflow <= found && (surv > NMAX);
      result.place_x       <= (found && (surv <= NMAX)) ? POS_BITS'(px) : '0;
      result.place_y       <= (found && (surv <= NMAX)) ? POS_BITS'(py) : '0;
    end
  end

endmodule

// ===== sv/maxrects_best_short_side_packer.sv =====
`timescale 1ns / 1ps
// MAXRECTS best-short-side-fit packer, top level: controller plus datapath.
// Depends on mrp_pkg, mrp_ctrl, mrp_datapath and mrp_ram.
//
// A request is taken when start is high, busy is low and no bin register is
// written; one result follows with a single-cycle done strobe that the
// receiver cannot hold off. With c free rectangles held, a miss ends after the
// fit scan; otherwise the split produces n <= 4c remainders, and the
// containment prune sweeps the scratch memory once per remainder, through its
// single read port. A finish state follows and done is high in the cycle
// after it. After reset and after a bin register write while idle or in init,
// the block is busy while the whole-bin entry is written.
// The free list is double-banked so a refused request leaves it untouched.
module maxrects_best_short_side_packer #(
  parameter int MAX_FREE_RECTS = 256,
  parameter int COORD_BITS     = 13
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  mrp_pkg::request_t                  request,
  output logic                               done,
  output mrp_pkg::result_t                   result,
  input  logic                               wr_en,
  input  logic [mrp_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [mrp_pkg::IMG_BITS-1:0]       wr_data
);
  import mrp_pkg::*;

  cmd_t    cmd;
  status_t status;

  mrp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .status(status), .cmd(cmd)
  );

  mrp_datapath #(
    .MAX_FREE_RECTS(MAX_FREE_RECTS),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .request(request),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .result(result)
  );

endmodule
